// ----- hdl/tpp_pkg.sv -----
// shared constants and types of the trapezoidal position profile
package tpp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int REG_W     = 31;
	localparam int IN_W      = 32;
	localparam int DIVN_W    = REG_W + FRAC_BITS;
	localparam int TIME_W    = DIVN_W + 2;
	localparam int VEL_W     = 2 * REG_W - FRAC_BITS;
	localparam int VHI_W     = VEL_W - 32;
	localparam int PROD_W    = VEL_W + REG_W;
	localparam int POS_W     = 63 - FRAC_BITS;
	localparam int ROOT_W    = 2 * REG_W;
	localparam int CNT_W     = $clog2(DIVN_W);
	localparam int IDX_W     = 2;

	localparam logic [IDX_W-1:0] REG_DISTANCE = 2'd0;
	localparam logic [IDX_W-1:0] REG_VELOCITY = 2'd1;
	localparam logic [IDX_W-1:0] REG_ACCEL    = 2'd2;

	typedef enum logic [2:0] {
		PH_ZERO,
		PH_ACCEL,
		PH_CRUISE,
		PH_DECEL,
		PH_HOLD
	} phase_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_MUL,
		SQ_CMP,
		SQ_DIV1,
		SQ_ROOT,
		SQ_DIV2
	} seq_state_t;

endpackage

// ----- hdl/tpp_stream_if.sv -----
// valid/ready channels for time samples and position commands
interface tpp_time_if;
	logic                           valid;
	logic                           ready;
	logic signed [tpp_pkg::IN_W-1:0] elapsed_time;
	modport source (output valid, output elapsed_time, input ready);
	modport sink (input valid, input elapsed_time, output ready);
endinterface

interface tpp_pos_if;
	logic                       valid;
	logic                       ready;
	logic [tpp_pkg::REG_W-1:0]  target_pos;
	modport source (output valid, output target_pos, input ready);
	modport sink (input valid, input target_pos, output ready);
endinterface

// ----- hdl/trapezoidal_position_profile_core.sv -----
// trapezoidal position profile evaluator: phase-time sequencer and seven-stage datapath
// One time sample is taken per clock while no recomputation runs, and its position is offered
// from the seventh stage register; stalls on the output hold the pipeline without loss, and
// bubbles close up. Each configuration write starts a recomputation of the phase times in a
// shared one-bit-per-cycle divider and square-root unit: input is held off after the last
// write until it ends, after two 47-step divisions in the trapezoid case, one division plus
// 31 root steps in the triangular case and one division when the triangular time saturates.
module trapezoidal_position_profile_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tpp_pkg::IDX_W-1:0]       cfg_index,
	input  logic [tpp_pkg::REG_W-1:0]       cfg_data,
	tpp_time_if.sink                        sample,
	tpp_pos_if.source                       command
);

	localparam int F   = tpp_pkg::FRAC_BITS;
	localparam int RW  = tpp_pkg::REG_W;
	localparam int DW  = tpp_pkg::DIVN_W;
	localparam int TW  = tpp_pkg::TIME_W;
	localparam int VW  = tpp_pkg::VEL_W;
	localparam int HW  = tpp_pkg::VHI_W;
	localparam int PW  = tpp_pkg::PROD_W;
	localparam int OW  = tpp_pkg::POS_W;
	localparam int QW  = tpp_pkg::ROOT_W;
	localparam int CW  = tpp_pkg::CNT_W;

	// configuration and phase times
	logic [RW-1:0] d_q, v_q, a_q;
	logic [RW-1:0] v_eff, a_eff;
	logic [TW-1:0] t1_q, t2_q, t3_q;

	tpp_pkg::seq_state_t state_q, state_n;
	logic [2*RW-1:0] vv_q, da_q;
	logic            tri_q;
	logic [DW-1:0]   num_q;
	logic [RW-1:0]   rem_q, den_q;
	logic [CW-1:0]   cnt_q;
	logic [QW-1:0]   x_q, bit_q;
	logic [QW:0]     root_q;

	logic [RW:0]     rem_sh;
	logic            qbit;
	logic [RW-1:0]   rem_n;
	logic [DW-1:0]   num_n;
	logic [QW:0]     root_sum, root_n;
	logic            root_take;
	logic            seq_idle;

	assign v_eff = (v_q == '0) ? RW'(1) : v_q;
	assign a_eff = (a_q == '0) ? RW'(1) : a_q;
	assign seq_idle = (state_q == tpp_pkg::SQ_IDLE);

	always_comb begin
		rem_sh = {rem_q, num_q[DW-1]};
		qbit   = (rem_sh >= {1'b0, den_q});
		rem_n  = qbit ? RW'(rem_sh - {1'b0, den_q}) : rem_sh[RW-1:0];
		num_n  = {num_q[DW-2:0], qbit};
		root_sum  = root_q + {1'b0, bit_q};
		root_take = ({1'b0, x_q} >= root_sum);
		root_n    = root_take ? ((root_q >> 1) + {1'b0, bit_q}) : (root_q >> 1);
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			tpp_pkg::SQ_IDLE: state_n = state_q;
			tpp_pkg::SQ_MUL:  state_n = tpp_pkg::SQ_CMP;
			tpp_pkg::SQ_CMP:  state_n = tpp_pkg::SQ_DIV1;
			tpp_pkg::SQ_DIV1: begin
				if (cnt_q == '0) begin
					if (!tri_q)
						state_n = tpp_pkg::SQ_DIV2;
					else if (64'(num_n) >= (64'd1 << (2 * RW - F)))
						state_n = tpp_pkg::SQ_IDLE;
					else
						state_n = tpp_pkg::SQ_ROOT;
				end
			end
			tpp_pkg::SQ_ROOT: if (cnt_q == '0) state_n = tpp_pkg::SQ_IDLE;
			tpp_pkg::SQ_DIV2: if (cnt_q == '0) state_n = tpp_pkg::SQ_IDLE;
			default:          state_n = tpp_pkg::SQ_IDLE;
		endcase
		if (cfg_we)
			state_n = tpp_pkg::SQ_MUL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpp_pkg::SQ_IDLE;
			d_q     <= '0;
			v_q     <= RW'(65536);
			a_q     <= RW'(65536);
			t1_q    <= '0;
			t2_q    <= '0;
			t3_q    <= '0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				case (cfg_index)
					tpp_pkg::REG_DISTANCE: d_q <= cfg_data;
					tpp_pkg::REG_VELOCITY: v_q <= cfg_data;
					tpp_pkg::REG_ACCEL:    a_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				tpp_pkg::SQ_DIV1: begin
					if (cnt_q == '0) begin
						if (!tri_q) begin
							t1_q <= TW'(num_n);
						end else if (64'(num_n) >= (64'd1 << (2 * RW - F))) begin
							t1_q <= TW'(1) << RW;
							t2_q <= TW'(1) << RW;
							t3_q <= TW'(1) << (RW + 1);
						end
					end
				end
				tpp_pkg::SQ_ROOT: begin
					if (cnt_q == '0) begin
						t1_q <= TW'(root_n);
						t2_q <= TW'(root_n);
						t3_q <= TW'(root_n) << 1;
					end
				end
				tpp_pkg::SQ_DIV2: begin
					if (cnt_q == '0) begin
						t2_q <= TW'(num_n);
						t3_q <= TW'(num_n) + t1_q;
					end
				end
				default: ;
			endcase
		end
	end

	// divider and root datapath
	always_ff @(posedge clk) begin
		case (state_q)
			tpp_pkg::SQ_MUL: begin
				vv_q <= {{RW{1'b0}}, v_eff} * {{RW{1'b0}}, v_eff};
				da_q <= {{RW{1'b0}}, d_q} * {{RW{1'b0}}, a_eff};
			end
			tpp_pkg::SQ_CMP: begin
				tri_q <= (vv_q > da_q);
				num_q <= (vv_q > da_q) ? DW'({d_q, {F{1'b0}}}) : DW'({v_eff, {F{1'b0}}});
				den_q <= a_eff;
				rem_q <= '0;
				cnt_q <= CW'(DW - 1);
			end
			tpp_pkg::SQ_DIV1: begin
				num_q <= num_n;
				rem_q <= rem_n;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					if (!tri_q) begin
						num_q <= DW'({d_q, {F{1'b0}}});
						den_q <= v_eff;
						rem_q <= '0;
						cnt_q <= CW'(DW - 1);
					end else begin
						x_q    <= QW'(64'(num_n) << F);
						root_q <= '0;
						bit_q  <= QW'(1) << (QW - 2);
						cnt_q  <= CW'(RW - 1);
					end
				end
			end
			tpp_pkg::SQ_ROOT: begin
				if (root_take)
					x_q <= QW'({1'b0, x_q} - root_sum);
				root_q <= root_n;
				bit_q  <= bit_q >> 2;
				cnt_q  <= cnt_q - 1'b1;
			end
			tpp_pkg::SQ_DIV2: begin
				num_q <= num_n;
				rem_q <= rem_n;
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	// pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !v_s7 || command.ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign sample.ready = en1 && seq_idle;

	localparam int IN_W_T = tpp_pkg::IN_W;
	logic [IN_W_T-1:0] t_s1;
	tpp_pkg::phase_t phase_s2, phase_s3, phase_s4, phase_s5, phase_s6;
	logic [RW-1:0]   r_s2, r_s3, dt_s2;
	logic [2*RW-1:0] ar_s3, vdt_s3, vdt_s4, vdt_s5, vdt_s6;
	logic [63:0]     plo_s4;
	logic [HW+RW-1:0] phi_s4;
	logic [PW-1:0]   prod_s5;
	logic [RW-1:0]   half_s6, pos_s7;

	// stage 1: phase decision
	tpp_pkg::phase_t phase_c;
	logic [TW-1:0]   tu;
	logic [RW-1:0]   r_c, dt_c;
	always_comb begin
		tu   = TW'(t_s1[RW-1:0]);
		r_c  = '0;
		dt_c = RW'(tu - t1_q);
		if (t_s1[IN_W_T-1]) begin
			phase_c = tpp_pkg::PH_ZERO;
		end else if (tu < t1_q) begin
			phase_c = tpp_pkg::PH_ACCEL;
			r_c     = t_s1[RW-1:0];
		end else if (tu < t2_q) begin
			phase_c = tpp_pkg::PH_CRUISE;
			r_c     = t1_q[RW-1:0];
		end else if (tu < t3_q) begin
			phase_c = tpp_pkg::PH_DECEL;
			r_c     = RW'(t3_q - tu);
		end else begin
			phase_c = tpp_pkg::PH_HOLD;
		end
	end

	// stage 3: velocity split
	logic [VW-1:0] vel_c;
	assign vel_c = ar_s3[2*RW-1:F];

	// stage 5: half distance saturated to d
	logic [OW-1:0] hpos_c;
	logic [RW-1:0] half_c;
	always_comb begin
		hpos_c = prod_s5[63:F+1];
		if ((|prod_s5[PW-1:64]) || (hpos_c > OW'(d_q)))
			half_c = d_q;
		else
			half_c = hpos_c[RW-1:0];
	end

	// stage 6: final selection
	logic [OW-1:0] cruise_c;
	logic [RW-1:0] pos_c;
	always_comb begin
		cruise_c = OW'(half_s6) + OW'(vdt_s6[2*RW-1:F]);
		case (phase_s6)
			tpp_pkg::PH_ZERO:   pos_c = '0;
			tpp_pkg::PH_ACCEL:  pos_c = half_s6;
			tpp_pkg::PH_CRUISE: pos_c = (cruise_c > OW'(d_q)) ? d_q : cruise_c[RW-1:0];
			tpp_pkg::PH_DECEL:  pos_c = d_q - half_s6;
			default:            pos_c = d_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= sample.valid && sample.ready;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) t_s1 <= sample.elapsed_time;
		if (en2) begin
			phase_s2 <= phase_c;
			r_s2     <= r_c;
			dt_s2    <= dt_c;
		end
		if (en3) begin
			phase_s3 <= phase_s2;
			r_s3     <= r_s2;
			ar_s3    <= {{RW{1'b0}}, a_eff} * {{RW{1'b0}}, r_s2};
			vdt_s3   <= {{RW{1'b0}}, v_eff} * {{RW{1'b0}}, dt_s2};
		end
		if (en4) begin
			phase_s4 <= phase_s3;
			vdt_s4   <= vdt_s3;
			plo_s4   <= 64'(vel_c[31:0]) * 64'(r_s3);
			phi_s4   <= (HW + RW)'(vel_c[VW-1:32]) * (HW + RW)'(r_s3);
		end
		if (en5) begin
			phase_s5 <= phase_s4;
			vdt_s5   <= vdt_s4;
			prod_s5  <= (PW'(phi_s4) << 32) + PW'(plo_s4);
		end
		if (en6) begin
			phase_s6 <= phase_s5;
			vdt_s6   <= vdt_s5;
			half_s6  <= half_c;
		end
		if (en7) pos_s7 <= pos_c;
	end

	assign command.valid      = v_s7;
	assign command.target_pos = pos_s7;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sample.ready |-> seq_idle)
		else $error("input taken while phase times recompute");

	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !sample.ready)
		else $error("input open right after a register write");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		command.valid |-> command.target_pos <= d_q)
		else $error("position beyond distance");

	a_time_order: assert property (@(posedge clk) disable iff (!arst_n)
		seq_idle |-> (t1_q <= t2_q) && (t2_q <= t3_q))
		else $error("phase times out of order");

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the trapezoidal position profile core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_W = tpp_pkg::IDX_W;
	localparam int REG_W = tpp_pkg::REG_W;
	localparam int IN_W = tpp_pkg::IN_W;
	localparam int FRAC_BITS = tpp_pkg::FRAC_BITS;
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam longint unsigned POS_MAX = 64'h7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0] cfg_data = '0;

	tpp_time_if sample_ch ();
	tpp_pos_if cmd_ch ();

	trapezoidal_position_profile_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(sample_ch),
		.command(cmd_ch)
	);

	always #4 clk = ~clk;

	longint unsigned distance_reg, velocity_reg, accel_reg;
	logic [REG_W-1:0] position_queue[$];
	bit steady_flow;
	int mismatch_count;
	int quiet_cycles;

	initial begin
		sample_ch.valid = 1'b0;
		sample_ch.elapsed_time = '0;
		cmd_ch.ready = 1'b0;
	end

	function automatic longint unsigned floor_root(longint unsigned x);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic longint unsigned ramp_distance(longint unsigned a, longint unsigned r,
			longint unsigned d);
		longint unsigned vel, pos;
		if (r == 0)
			return 0;
		if (a > 64'hFFFF_FFFF_FFFF_FFFF / r)
			return d;
		vel = (a * r) >> FRAC_BITS;
		if (vel != 0 && vel > 64'hFFFF_FFFF_FFFF_FFFF / r)
			return d;
		pos = (vel * r) >> (FRAC_BITS + 1);
		return pos > d ? d : pos;
	endfunction

	function automatic void phase_times(output longint unsigned t1, output longint unsigned t2,
			output longint unsigned t3);
		longint unsigned d, v, a, q;
		d = distance_reg;
		v = velocity_reg == 0 ? 1 : velocity_reg;
		a = accel_reg == 0 ? 1 : accel_reg;
		if (v * v > d * a) begin
			q = (d << FRAC_BITS) / a;
			if (q >= (64'd1 << (62 - FRAC_BITS)))
				t1 = 64'd1 << 31;
			else
				t1 = floor_root(q << FRAC_BITS);
			t2 = t1;
			t3 = t1 + t1;
		end else begin
			t1 = (v << FRAC_BITS) / a;
			t2 = (d << FRAC_BITS) / v;
			t3 = t2 + t1;
		end
	endfunction

	function automatic logic [REG_W-1:0] profile_position(logic signed [IN_W-1:0] elapsed);
		longint unsigned d, v, a, t1, t2, t3, t, pos;
		d = distance_reg;
		v = velocity_reg == 0 ? 1 : velocity_reg;
		a = accel_reg == 0 ? 1 : accel_reg;
		phase_times(t1, t2, t3);
		if (elapsed < 0) begin
			pos = 0;
		end else begin
			t = longint'(elapsed);
			if (t < t1) begin
				pos = ramp_distance(a, t, d);
			end else if (t < t2) begin
				pos = ramp_distance(a, t1, d) + ((v * (t - t1)) >> FRAC_BITS);
				if (pos > d)
					pos = d;
			end else if (t < t3) begin
				pos = d - ramp_distance(a, t3 - t, d);
			end else begin
				pos = d;
			end
		end
		return pos[REG_W-1:0];
	endfunction

	function automatic logic signed [IN_W-1:0] near_time(longint unsigned x);
		longint s;
		s = longint'(x) + $urandom_range(0, 128) - 64;
		if (s > longint'(POS_MAX))
			s = longint'(POS_MAX);
		return s[IN_W-1:0];
	endfunction

	function automatic logic signed [IN_W-1:0] pick_time();
		longint unsigned t1, t2, t3, span;
		phase_times(t1, t2, t3);
		span = t3 + t3 / 8 + 16;
		if (span > POS_MAX)
			span = POS_MAX;
		case ($urandom_range(0, 9))
			0: return $urandom;
			1, 2: return near_time(t1);
			3, 4: return near_time(t2);
			5, 6: return near_time(t3);
			default: return IN_W'(({$urandom, $urandom}) % (span + 1));
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [REG_W-1:0] got, logic [REG_W-1:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatch_count++;
	endtask

	task automatic send_sample(logic signed [IN_W-1:0] elapsed);
		@(negedge clk);
		if (!steady_flow && $urandom_range(0, 99) < 19) begin
			sample_ch.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		sample_ch.valid = 1'b1;
		sample_ch.elapsed_time = elapsed;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		position_queue.push_back(profile_position(elapsed));
	endtask

	task automatic drain_results();
		@(negedge clk);
		sample_ch.valid = 1'b0;
		while (position_queue.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_register(logic [IDX_W-1:0] idx, longint unsigned value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value[REG_W-1:0];
		case (idx)
			tpp_pkg::REG_DISTANCE: distance_reg = value & POS_MAX;
			tpp_pkg::REG_VELOCITY: velocity_reg = value & POS_MAX;
			tpp_pkg::REG_ACCEL: accel_reg = value & POS_MAX;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_move(longint unsigned d, longint unsigned v, longint unsigned a);
		drain_results();
		write_register(tpp_pkg::REG_DISTANCE, d);
		write_register(tpp_pkg::REG_VELOCITY, v);
		write_register(tpp_pkg::REG_ACCEL, a);
	endtask

	task automatic test_reset_values();
		send_sample(0);
		send_sample(32'sh0001_0000);
		send_sample(32'sh8000_0000);
		send_sample(32'sh7FFF_FFFF);
	endtask

	task automatic test_profile_phases();
		longint unsigned t1, t2, t3;
		set_move(64'd10 << 16, 64'd2 << 16, 64'd1 << 16);
		phase_times(t1, t2, t3);
		send_sample(-1);
		send_sample(0);
		send_sample(IN_W'(t1 / 2));
		send_sample(IN_W'(t1));
		send_sample(IN_W'((t1 + t2) / 2));
		send_sample(IN_W'(t2));
		send_sample(IN_W'((t2 + t3) / 2));
		send_sample(IN_W'(t3 - 1));
		send_sample(IN_W'(t3));
		// triangular move, cruise speed never reached
		set_move(64'd1 << 16, 64'd100 << 16, 64'd1 << 16);
		phase_times(t1, t2, t3);
		send_sample(IN_W'(t1 - 1));
		send_sample(IN_W'(t1));
		send_sample(IN_W'(t3 - 1));
		send_sample(IN_W'(t3));
	endtask

	task automatic test_special_registers();
		set_move(0, 64'd3 << 16, 64'd5 << 16);
		send_sample(0);
		send_sample(32'sh7FFF_FFFF);
		set_move(64'd50 << 16, 0, 0);
		send_sample(32'sh0100_0000);
		send_sample(32'sh7FFF_FFFF);
		set_move(POS_MAX, POS_MAX, POS_MAX);
		send_sample(32'sh4000_0000);
		send_sample(32'sh7FFF_FFFF);
		set_move(POS_MAX, 1, 1);
		send_sample(32'sh7FFF_FFFF);
		drain_results();
		write_register(REG_UNUSED, POS_MAX);
		send_sample(32'sh0000_8000);
	endtask

	function automatic longint unsigned pick_register();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 3);
			1: return POS_MAX - $urandom_range(0, 3);
			2: return $urandom_range(1 << 12, 1 << 20);
			3: return $urandom_range(1 << 16, 1 << 24);
			default: return $urandom & POS_MAX;
		endcase
	endfunction

	task automatic test_random_moves();
		for (int phase = 0; phase < 10; phase++) begin
			set_move(pick_register(), pick_register(), pick_register());
			steady_flow = (phase == 4);
			repeat (100) send_sample(pick_time());
		end
		steady_flow = 1'b0;
	endtask

	always @(negedge clk)
		cmd_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 19);

	always @(posedge clk) begin
		if (cmd_ch.valid && cmd_ch.ready) begin
			if (position_queue.size() == 0)
				report_mismatch("unexpected item", cmd_ch.target_pos, '0);
			else if (cmd_ch.target_pos !== position_queue[0])
				report_mismatch("target_pos", cmd_ch.target_pos,
					position_queue.pop_front());
			else
				void'(position_queue.pop_front());
		end
		if ((cmd_ch.valid && cmd_ch.ready) || (sample_ch.valid && sample_ch.ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		mismatch_count = 0;
		quiet_cycles = 0;
		steady_flow = 1'b0;
		distance_reg = 0;
		velocity_reg = 65536;
		accel_reg = 65536;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_values();
		test_profile_phases();
		test_special_registers();
		test_random_moves();
		drain_results();
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
